FILE: rtl/assert_macros.svh
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the usual clk_i / rst_ni pair.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/gmpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpq_pkg
// Shared types and codes of the grouped minimum priority queue.
// ----------------------------------------------------------------------------
package gmpq_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD       = 2'd0,
    FUNC_POP_GROUP = 2'd1,
    FUNC_POP_MIN   = 2'd2,
    FUNC_NONE      = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  group;
    logic [31:0] item_id;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] removed_id;
  } rsp_t;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_CLEAR, CMD_LOAD, CMD_DISPATCH, CMD_FAIL_EMPTY, CMD_FAIL_FULL,
    CMD_RD_CNT, CMD_LAT_CNT, CMD_A_INIT, CMD_A_UP_RD, CMD_A_UP_CMP,
    CMD_P_RD0, CMD_P_ROOT, CMD_P_RDLAST, CMD_P_LAST,
    CMD_G_DN_RDL, CMD_G_DN_LATL, CMD_G_DN_R, CMD_G_DN_CMP, CMD_G_WR,
    CMD_G_ROOT_RD, CMD_G_ROOT, CMD_E_POS_RD, CMD_E_CHK,
    CMD_T_UP_RD, CMD_T_UP_CMP, CMD_T_DN_RDL, CMD_T_DN_LATL, CMD_T_DN_R,
    CMD_T_DN_CMP, CMD_T_WR
  } cmd_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_FAIL_EMPTY, S_FAIL_FULL,
    S_RD_CNT, S_LAT_CNT, S_A_INIT, S_A_UP_RD, S_A_UP_CMP,
    S_P_RD0, S_P_ROOT, S_P_RDLAST, S_P_LAST,
    S_G_DN_RDL, S_G_DN_LATL, S_G_DN_R, S_G_DN_CMP, S_G_WR,
    S_G_ROOT_RD, S_G_ROOT, S_E_POS_RD, S_E_CHK,
    S_T_UP_RD, S_T_UP_CMP, S_T_DN_RDL, S_T_DN_LATL, S_T_DN_R,
    S_T_DN_CMP, S_T_WR, S_DONE
  } state_e;

  typedef struct packed {
    logic clr_last;
    logic is_add;
    logic is_popg;
    logic is_popq;
    logic g_ok;
    logic cnt_full;
    logic cnt_zero;
    logic tc_zero;
    logic i_zero;
    logic e_lt_rd;
    logic g_l_ok;
    logic g_r_ok;
    logic c_lt_e;
    logic n_one;
    logic newgrp;
    logic top_full;
    logic pos_bad;
    logic p_last;
    logic ti_zero;
    logic t_lt_rd;
    logic t_l_ok;
    logic t_r_ok;
    logic c_lt_t;
    logic moved;
  } flags_t;

endpackage

FILE: rtl/gmpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpq_ram
// Generic single-write, single-read RAM with registered read (old data).
// ----------------------------------------------------------------------------
module gmpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gmpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpq_ctrl
// Sequencer for the two-level heap: issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module gmpq_ctrl
  import gmpq_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  flags_t flags_i,
  output cmd_e   cmd_o,
  output logic   busy_o,
  output logic   done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:      if (flags_i.clr_last) state_d = S_IDLE;
      S_IDLE:       if (start_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        priority if (flags_i.is_add) begin
          state_d = (!flags_i.g_ok || flags_i.cnt_full) ? S_FAIL_FULL : S_A_INIT;
        end else if (flags_i.is_popg) begin
          state_d = (!flags_i.g_ok || flags_i.cnt_zero) ? S_FAIL_EMPTY : S_P_RD0;
        end else if (flags_i.is_popq) begin
          state_d = flags_i.tc_zero ? S_FAIL_EMPTY : S_RD_CNT;
        end else begin
          state_d = S_FAIL_EMPTY;
        end
      end
      S_FAIL_EMPTY: state_d = S_DONE;
      S_FAIL_FULL:  state_d = S_DONE;
      S_RD_CNT:     state_d = S_LAT_CNT;
      S_LAT_CNT:    state_d = S_P_RD0;
      S_A_INIT:     state_d = S_A_UP_RD;
      S_A_UP_RD:    state_d = flags_i.i_zero ? S_G_WR : S_A_UP_CMP;
      S_A_UP_CMP:   state_d = flags_i.e_lt_rd ? S_A_UP_RD : S_G_WR;
      S_P_RD0:      state_d = S_P_ROOT;
      S_P_ROOT:     state_d = flags_i.n_one ? S_E_POS_RD : S_P_RDLAST;
      S_P_RDLAST:   state_d = S_P_LAST;
      S_P_LAST:     state_d = S_G_DN_RDL;
      S_G_DN_RDL:   state_d = flags_i.g_l_ok ? S_G_DN_LATL : S_G_WR;
      S_G_DN_LATL:  state_d = flags_i.g_r_ok ? S_G_DN_R : S_G_DN_CMP;
      S_G_DN_R:     state_d = S_G_DN_CMP;
      S_G_DN_CMP:   state_d = flags_i.c_lt_e ? S_G_DN_RDL : S_G_WR;
      S_G_WR:       state_d = S_G_ROOT_RD;
      S_G_ROOT_RD:  state_d = S_G_ROOT;
      S_G_ROOT: begin
        if (flags_i.newgrp) begin
          state_d = flags_i.top_full ? S_DONE : S_T_UP_RD;
        end else begin
          state_d = flags_i.pos_bad ? S_DONE : S_T_UP_RD;
        end
      end
      S_E_POS_RD:   state_d = S_E_CHK;
      S_E_CHK:      state_d = (flags_i.pos_bad || flags_i.p_last) ? S_DONE : S_T_UP_RD;
      S_T_UP_RD: begin
        if (flags_i.ti_zero) begin
          state_d = flags_i.moved ? S_T_WR : S_T_DN_RDL;
        end else begin
          state_d = S_T_UP_CMP;
        end
      end
      S_T_UP_CMP: begin
        if (flags_i.t_lt_rd) begin
          state_d = S_T_UP_RD;
        end else begin
          state_d = flags_i.moved ? S_T_WR : S_T_DN_RDL;
        end
      end
      S_T_DN_RDL:   state_d = flags_i.t_l_ok ? S_T_DN_LATL : S_T_WR;
      S_T_DN_LATL:  state_d = flags_i.t_r_ok ? S_T_DN_R : S_T_DN_CMP;
      S_T_DN_R:     state_d = S_T_DN_CMP;
      S_T_DN_CMP:   state_d = flags_i.c_lt_t ? S_T_DN_RDL : S_T_WR;
      S_T_WR:       state_d = S_DONE;
      S_DONE:       state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = CMD_NOP;
    busy_o = (state_q != S_IDLE);
    done_o = (state_q == S_DONE);
    unique case (state_q)
      S_CLEAR:      cmd_o = CMD_CLEAR;
      S_IDLE:       cmd_o = start_i ? CMD_LOAD : CMD_NOP;
      S_DISPATCH:   cmd_o = CMD_DISPATCH;
      S_FAIL_EMPTY: cmd_o = CMD_FAIL_EMPTY;
      S_FAIL_FULL:  cmd_o = CMD_FAIL_FULL;
      S_RD_CNT:     cmd_o = CMD_RD_CNT;
      S_LAT_CNT:    cmd_o = CMD_LAT_CNT;
      S_A_INIT:     cmd_o = CMD_A_INIT;
      S_A_UP_RD:    cmd_o = CMD_A_UP_RD;
      S_A_UP_CMP:   cmd_o = CMD_A_UP_CMP;
      S_P_RD0:      cmd_o = CMD_P_RD0;
      S_P_ROOT:     cmd_o = CMD_P_ROOT;
      S_P_RDLAST:   cmd_o = CMD_P_RDLAST;
      S_P_LAST:     cmd_o = CMD_P_LAST;
      S_G_DN_RDL:   cmd_o = CMD_G_DN_RDL;
      S_G_DN_LATL:  cmd_o = CMD_G_DN_LATL;
      S_G_DN_R:     cmd_o = CMD_G_DN_R;
      S_G_DN_CMP:   cmd_o = CMD_G_DN_CMP;
      S_G_WR:       cmd_o = CMD_G_WR;
      S_G_ROOT_RD:  cmd_o = CMD_G_ROOT_RD;
      S_G_ROOT:     cmd_o = CMD_G_ROOT;
      S_E_POS_RD:   cmd_o = CMD_E_POS_RD;
      S_E_CHK:      cmd_o = CMD_E_CHK;
      S_T_UP_RD:    cmd_o = CMD_T_UP_RD;
      S_T_UP_CMP:   cmd_o = CMD_T_UP_CMP;
      S_T_DN_RDL:   cmd_o = CMD_T_DN_RDL;
      S_T_DN_LATL:  cmd_o = CMD_T_DN_LATL;
      S_T_DN_R:     cmd_o = CMD_T_DN_R;
      S_T_DN_CMP:   cmd_o = CMD_T_DN_CMP;
      S_T_WR:       cmd_o = CMD_T_WR;
      S_DONE:       cmd_o = CMD_NOP;
      default:      cmd_o = CMD_NOP;
    endcase
  end

endmodule

FILE: rtl/gmpq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpq_dp
// Datapath: heap memories, sift registers and compares, driven by commands.
// ----------------------------------------------------------------------------
module gmpq_dp
  import gmpq_pkg::*;
#(
  parameter int NUM_GROUPS  = 256,
  parameter int GROUP_DEPTH = 256,
  parameter int ID_BITS     = 32,
  parameter int KEY_BITS    = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cmd_e   cmd_i,
  input  req_t   req_i,
  output flags_t flags_o,
  output rsp_t   rsp_o
);

  localparam int IW = (ID_BITS < 32) ? ID_BITS : 32;
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int GW = $clog2(NUM_GROUPS);
  localparam int DW = $clog2(GROUP_DEPTH);
  localparam int HW = KW + IW;
  localparam int TW = GW + KW + IW;
  localparam int HDEPTH = NUM_GROUPS * GROUP_DEPTH;
  localparam int AW = $clog2(HDEPTH);

  function automatic logic hless(input logic [HW-1:0] a, input logic [HW-1:0] b);
    if (a[HW-1:IW] != b[HW-1:IW]) begin
      return a[HW-1:IW] < b[HW-1:IW];
    end
    return a[IW-1:0] < b[IW-1:0];
  endfunction

  function automatic logic tless(input logic [TW-1:0] a, input logic [TW-1:0] b);
    if (a[KW+IW-1:IW] != b[KW+IW-1:IW]) begin
      return a[KW+IW-1:IW] < b[KW+IW-1:IW];
    end
    return a[TW-1:KW+IW] < b[TW-1:KW+IW];
  endfunction

  // control registers
  logic [GW:0]   tc_q, tc_d;
  logic [GW-1:0] clr_q, clr_d;
  // operation registers
  logic [1:0]    func_q;
  logic          g_ok_q;
  logic [GW-1:0] g_q;
  logic [DW:0]   n_q;
  logic [DW-1:0] i_q, hci_q;
  logic [HW-1:0] e_q, hc_q;
  logic [GW-1:0] ti_q, tci_q;
  logic [TW-1:0] t_q, tch_q;
  logic          moved_q;
  logic [1:0]    res_status_q;
  logic [IW-1:0] res_id_q;

  // memory ports
  logic          h_we, c_we, t_we, p_we;
  logic [AW-1:0] h_waddr, h_raddr;
  logic [HW-1:0] h_wdata, h_rd;
  logic [GW-1:0] c_waddr, c_raddr, t_waddr, t_raddr, p_waddr, p_raddr, p_wdata, p_rd;
  logic [DW:0]   c_wdata, c_rd;
  logic [TW-1:0] t_wdata, t_rd;
  logic [DW-1:0] h_ridx;

  // index arithmetic
  logic [DW:0]   gl;
  logic [DW+1:0] gr;
  logic [DW-1:0] gp;
  logic [GW:0]   tl;
  logic [GW+1:0] tr;
  logic [GW-1:0] tp;
  logic [AW-1:0] hbase;

  assign gl    = {i_q, 1'b1};
  assign gr    = {1'b0, gl} + 1'b1;
  assign gp    = (i_q - 1'b1) >> 1;
  assign tl    = {ti_q, 1'b1};
  assign tr    = {1'b0, tl} + 1'b1;
  assign tp    = (ti_q - 1'b1) >> 1;
  assign hbase = AW'(g_q) * AW'(GROUP_DEPTH);

  gmpq_ram #(.WIDTH(HW), .DEPTH(HDEPTH)) u_heap_ram (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rd)
  );
  gmpq_ram #(.WIDTH(DW + 1), .DEPTH(NUM_GROUPS)) u_cnt_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rd)
  );
  gmpq_ram #(.WIDTH(TW), .DEPTH(NUM_GROUPS)) u_top_ram (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rd)
  );
  gmpq_ram #(.WIDTH(GW), .DEPTH(NUM_GROUPS)) u_pos_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rd)
  );

  // memory addressing
  always_comb begin
    h_ridx  = '0;
    h_we    = 1'b0;
    h_wdata = e_q;
    c_raddr = g_q;
    c_we    = 1'b0;
    c_waddr = g_q;
    c_wdata = '0;
    t_raddr = '0;
    t_we    = 1'b0;
    t_waddr = ti_q;
    t_wdata = t_q;
    p_raddr = g_q;
    p_we    = 1'b0;
    p_waddr = t_q[TW-1:KW+IW];
    p_wdata = ti_q;
    unique case (cmd_i)
      CMD_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_q;
      end
      CMD_LOAD:   c_raddr = GW'(req_i.group);
      CMD_A_INIT: begin
        c_we    = 1'b1;
        c_wdata = n_q + 1'b1;
      end
      CMD_A_UP_RD:  h_ridx = gp;
      CMD_A_UP_CMP: begin
        h_we    = hless(e_q, h_rd);
        h_wdata = h_rd;
      end
      CMD_P_ROOT: begin
        c_we    = 1'b1;
        c_wdata = n_q - 1'b1;
      end
      CMD_P_RDLAST:  h_ridx = n_q[DW-1:0];
      CMD_G_DN_RDL:  h_ridx = gl[DW-1:0];
      CMD_G_DN_LATL: h_ridx = gr[DW-1:0];
      CMD_G_DN_CMP: begin
        h_we    = hless(hc_q, e_q);
        h_wdata = hc_q;
      end
      CMD_G_WR: h_we = 1'b1;
      CMD_G_ROOT: begin
        p_we    = (n_q == '0) && (func_q == FUNC_ADD) && (tc_q != (GW+1)'(NUM_GROUPS));
        p_waddr = g_q;
        p_wdata = tc_q[GW-1:0];
      end
      CMD_E_POS_RD: t_raddr = GW'(tc_q - 1'b1);
      CMD_T_UP_RD:  t_raddr = tp;
      CMD_T_UP_CMP: begin
        t_we    = tless(t_q, t_rd);
        t_wdata = t_rd;
        p_we    = t_we;
        p_waddr = t_rd[TW-1:KW+IW];
      end
      CMD_T_DN_RDL:  t_raddr = tl[GW-1:0];
      CMD_T_DN_LATL: t_raddr = tr[GW-1:0];
      CMD_T_DN_CMP: begin
        t_we    = tless(tch_q, t_q);
        t_wdata = tch_q;
        p_we    = t_we;
        p_waddr = tch_q[TW-1:KW+IW];
      end
      CMD_T_WR: begin
        t_we = 1'b1;
        p_we = 1'b1;
      end
      default: ;
    endcase
    h_raddr = hbase + AW'(h_ridx);
    h_waddr = hbase + AW'(i_q);
  end

  // control registers
  always_comb begin
    tc_d  = tc_q;
    clr_d = clr_q;
    unique case (cmd_i)
      CMD_CLEAR: clr_d = clr_q + 1'b1;
      CMD_G_ROOT: begin
        if ((n_q == '0) && (func_q == FUNC_ADD) && (tc_q != (GW+1)'(NUM_GROUPS))) begin
          tc_d = tc_q + 1'b1;
        end
      end
      CMD_E_CHK: if ({1'b0, p_rd} < tc_q) tc_d = tc_q - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q  <= '0;
      clr_q <= '0;
    end else begin
      tc_q  <= tc_d;
      clr_q <= clr_d;
    end
  end

  // operation registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        func_q <= req_i.func;
        g_ok_q <= ({24'd0, req_i.group} < 32'(NUM_GROUPS));
        g_q    <= GW'(req_i.group);
        e_q    <= {KW'(req_i.key), IW'(req_i.item_id)};
      end
      CMD_DISPATCH: begin
        n_q          <= c_rd;
        res_status_q <= ST_OK;
        res_id_q     <= '0;
        if (func_q == FUNC_POP_MIN) g_q <= t_rd[TW-1:KW+IW];
      end
      CMD_FAIL_EMPTY: res_status_q <= ST_EMPTY;
      CMD_FAIL_FULL:  res_status_q <= ST_FULL;
      CMD_LAT_CNT:    n_q <= c_rd;
      CMD_A_INIT:     i_q <= n_q[DW-1:0];
      CMD_A_UP_CMP:   if (hless(e_q, h_rd)) i_q <= gp;
      CMD_P_ROOT: begin
        res_id_q <= h_rd[IW-1:0];
        n_q      <= n_q - 1'b1;
        i_q      <= '0;
      end
      CMD_P_LAST: e_q <= h_rd;
      CMD_G_DN_LATL: begin
        hc_q  <= h_rd;
        hci_q <= gl[DW-1:0];
      end
      CMD_G_DN_R: begin
        if (hless(h_rd, hc_q)) begin
          hc_q  <= h_rd;
          hci_q <= gr[DW-1:0];
        end
      end
      CMD_G_DN_CMP: if (hless(hc_q, e_q)) i_q <= hci_q;
      CMD_G_ROOT: begin
        t_q     <= {g_q, h_rd};
        moved_q <= 1'b0;
        ti_q    <= ((n_q == '0) && (func_q == FUNC_ADD)) ? tc_q[GW-1:0] : p_rd;
      end
      CMD_E_CHK: begin
        t_q     <= t_rd;
        ti_q    <= p_rd;
        moved_q <= 1'b0;
      end
      CMD_T_UP_CMP: begin
        if (tless(t_q, t_rd)) begin
          ti_q    <= tp;
          moved_q <= 1'b1;
        end
      end
      CMD_T_DN_LATL: begin
        tch_q <= t_rd;
        tci_q <= tl[GW-1:0];
      end
      CMD_T_DN_R: begin
        if (tless(t_rd, tch_q)) begin
          tch_q <= t_rd;
          tci_q <= tr[GW-1:0];
        end
      end
      CMD_T_DN_CMP: if (tless(tch_q, t_q)) ti_q <= tci_q;
      default: ;
    endcase
  end

  // status towards the sequencer
  always_comb begin
    flags_o.clr_last = (clr_q == GW'(NUM_GROUPS - 1));
    flags_o.is_add   = (func_q == FUNC_ADD);
    flags_o.is_popg  = (func_q == FUNC_POP_GROUP);
    flags_o.is_popq  = (func_q == FUNC_POP_MIN);
    flags_o.g_ok     = g_ok_q;
    flags_o.cnt_full = (c_rd == (DW+1)'(GROUP_DEPTH));
    flags_o.cnt_zero = (c_rd == '0);
    flags_o.tc_zero  = (tc_q == '0);
    flags_o.i_zero   = (i_q == '0);
    flags_o.e_lt_rd  = hless(e_q, h_rd);
    flags_o.g_l_ok   = (gl < n_q);
    flags_o.g_r_ok   = (gr < {1'b0, n_q});
    flags_o.c_lt_e   = hless(hc_q, e_q);
    flags_o.n_one    = (n_q == (DW+1)'(1));
    flags_o.newgrp   = (n_q == '0) && (func_q == FUNC_ADD);
    flags_o.top_full = (tc_q == (GW+1)'(NUM_GROUPS));
    flags_o.pos_bad  = ({1'b0, p_rd} >= tc_q);
    flags_o.p_last   = ({1'b0, p_rd} == (tc_q - 1'b1));
    flags_o.ti_zero  = (ti_q == '0);
    flags_o.t_lt_rd  = tless(t_q, t_rd);
    flags_o.t_l_ok   = (tl < tc_q);
    flags_o.t_r_ok   = (tr < {1'b0, tc_q});
    flags_o.c_lt_t   = tless(tch_q, t_q);
    flags_o.moved    = moved_q;
  end

  assign rsp_o.status     = res_status_q;
  assign rsp_o.removed_id = 32'(res_id_q);

endmodule

FILE: rtl/grouped_min_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_min_priority_queue_top
// Two-level min priority queue: per-group heaps under a global heap of groups.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_i and raise start; the transfer happens on the
//   rising edge where start is high and busy is low. busy stays high until
//   the result has been shown.
//   Result channel: rsp_o is valid for exactly one cycle with done_o high.
//   The receiver cannot stall it; sample it on that edge.
//   Sequence: a rejected command goes from dispatch through a fail state to
//   the result. The time of an add or a pop grows with every level moved up
//   or down in the group heap, and again with every level moved in the global
//   heap. After each result the block returns to idle, where the next transfer
//   can be taken.
//   One command is in flight at a time; the rate is set by the single read
//   port of the heap memories and the compare-then-move loop over heap levels.
//   Reset: all control state clears at once, then a clearing pass zeroes the
//   group fill counts, one group per cycle, with busy high.
//   Heap contents need no clearing: only slots below a fill count are read.
// ----------------------------------------------------------------------------
module grouped_min_priority_queue_top
  import gmpq_pkg::*;
#(
  parameter int NUM_GROUPS  = 256,
  parameter int GROUP_DEPTH = 256,
  parameter int ID_BITS     = 32,
  parameter int KEY_BITS    = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  cmd_e   cmd;    // command from sequencer to datapath
  flags_t flags;  // compare and count status back to the sequencer

  // Sequencer: one state per memory access or compare step.
  gmpq_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .flags_i (flags),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Datapath: heap memories, fill counts, sift registers and the result.
  gmpq_dp #(
    .NUM_GROUPS  (NUM_GROUPS),
    .GROUP_DEPTH (GROUP_DEPTH),
    .ID_BITS     (ID_BITS),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i   (cmd),
    .req_i   (req_i),
    .flags_o (flags),
    .rsp_o   (rsp_o)
  );

endmodule

FILE: rtl/gmpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpq_checker
// Port-level checks on the priority queue's command and result channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gmpq_checker
  import gmpq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  `ASSERT_STD(a_done_while_busy, done_o |-> busy, "result shown while not busy")
  `ASSERT_STD(a_accept_busy, (start && !busy) |=> (busy && !done_o), "transfer not held busy")
  `ASSERT_STD(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `ASSERT_STD(a_status_code, done_o |-> (rsp_o.status <= ST_FULL), "bad status code")
  `ASSERT_STD(a_fail_no_id, (done_o && rsp_o.status != ST_OK) |-> (rsp_o.removed_id == '0), "id on failed command")

endmodule

bind grouped_min_priority_queue_top gmpq_checker u_gmpq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
